[hw/rtl/itra_pkg.sv]
// Shared types, constants and the digit-to-character mapping for the radix converter.
package itra_pkg;

  localparam int VALUE_WIDTH_DEF = 64;   // default conversion width
  localparam int FIELD_WIDTH     = 64;   // width of the value_bits port
  localparam int RADIX_BITS      = 6;
  localparam int CHAR_BITS       = 7;
  localparam int DIGIT_BITS      = 8;    // quotient bits resolved per divide cycle

  localparam logic [RADIX_BITS-1:0] RADIX_DEFAULT = 6'd10;
  localparam logic [RADIX_BITS-1:0] RADIX_MAX     = 6'd36;
  localparam logic [RADIX_BITS-1:0] RADIX_MIN     = 6'd2;

  localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 7'd48;
  localparam logic [CHAR_BITS-1:0] LOWER_OFFSET = 7'd39;
  localparam logic [CHAR_BITS-1:0] UPPER_OFFSET = 7'd7;
  localparam logic [RADIX_BITS-1:0] DECIMAL_LIMIT = 6'd10;

  // Conversion request as it travels from the front end to the back end
  typedef struct packed {
    logic                  sign;
    logic [RADIX_BITS-1:0] radix;
    logic                  upper;
  } conv_ctrl_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIVIDE,
    BK_EMIT,
    BK_FINISH
  } back_state_t;

  function automatic logic [CHAR_BITS-1:0] digit_char(input logic [RADIX_BITS-1:0] d,
                                                      input logic up);
    logic [CHAR_BITS-1:0] base;
    base = CHAR_ZERO + {1'b0, d};
    if (d < DECIMAL_LIMIT) begin
      digit_char = base;
    end else if (up) begin
      digit_char = base + UPPER_OFFSET;
    end else begin
      digit_char = base + LOWER_OFFSET;
    end
  endfunction

endpackage

[hw/rtl/itra_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module itra_ram
  #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
  )
  (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
  );

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/itra_queue.sv]
// Two-entry request queue between the front end and the back end.
module itra_queue
  #(
    parameter int WIDTH = 8
  )
  (
    input  logic             clk,
    input  logic             rst,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty,
    output logic             full
  );

  logic [WIDTH-1:0] entry [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign empty    = (count == 2'd0);
  assign full     = (count == 2'd2);
  assign pop_data = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_data;
    end
  end

endmodule

[hw/rtl/itra_front.sv]
// Front end: takes input words, extracts magnitude and sign, normalizes the radix.
module itra_front
  import itra_pkg::*;
  #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
  )
  (
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [FIELD_WIDTH-1:0] value_bits,
    input  logic                   is_signed,
    input  logic [RADIX_BITS-1:0]  radix,
    input  logic                   upper_case,
    input  logic                   q_full,
    output logic                   push,
    output logic [VALUE_WIDTH-1:0] mag,
    output conv_ctrl_t             ctrl
  );

  logic [VALUE_WIDTH-1:0] v;
  logic                   neg;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  assign v   = value_bits[VALUE_WIDTH-1:0];
  assign neg = is_signed && v[VALUE_WIDTH-1];
  // two's complement negate also covers the most negative value exactly
  assign mag = neg ? (~v + VALUE_WIDTH'(1)) : v;

  always_comb begin
    ctrl.sign  = neg;
    ctrl.upper = upper_case;
    if (radix < RADIX_MIN) begin
      ctrl.radix = RADIX_DEFAULT;
    end else if (radix > RADIX_MAX) begin
      ctrl.radix = RADIX_MAX;
    end else begin
      ctrl.radix = radix;
    end
  end

endmodule

[hw/rtl/itra_back.sv]
// Back end: divides out digits into the digit store, then emits them most significant first.
module itra_back
  import itra_pkg::*;
  #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
  )
  (
    input  logic                   clk,
    input  logic                   rst,
    input  logic                   q_empty,
    output logic                   pop,
    input  logic [VALUE_WIDTH-1:0] q_mag,
    input  conv_ctrl_t             q_ctrl,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [CHAR_BITS-1:0]   char_code,
    output logic                   negative,
    output logic                   last
  );

  localparam int STEPS = (VALUE_WIDTH + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int QW    = STEPS * DIGIT_BITS;
  localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int AW    = $clog2(VALUE_WIDTH);
  localparam int CW    = $clog2(VALUE_WIDTH + 1);

  back_state_t           state, state_next;
  logic [QW-1:0]         quo;
  logic [RADIX_BITS-1:0] rem;
  logic [SW-1:0]         step;
  logic [CW-1:0]         cnt;
  logic [AW-1:0]         idx;
  logic                  rd_pending;
  logic                  last_pend;
  conv_ctrl_t            cur;

  logic [RADIX_BITS:0]   r;
  logic [DIGIT_BITS-1:0] qb;
  logic [QW+DIGIT_BITS-1:0] div_shift;
  logic                  last_step;
  logic                  done;
  logic                  working;
  logic                  issue;
  logic                  ram_we;
  logic [RADIX_BITS-1:0] ram_rdata;

  // Eight steps of restoring division on the narrow remainder
  always_comb begin
    r  = {1'b0, rem};
    qb = '0;
    for (int i = 0; i < DIGIT_BITS; i++) begin
      r = {r[RADIX_BITS-1:0], quo[QW-1-i]};
      if (r >= {1'b0, cur.radix}) begin
        r = r - {1'b0, cur.radix};
        qb[DIGIT_BITS-1-i] = 1'b1;
      end
    end
  end

  assign div_shift = {quo, qb};
  assign last_step = (step == SW'(STEPS - 1));
  assign done      = (state == BK_DIVIDE) && (step == '0) && (cnt != '0) && (quo == '0);
  assign working   = (state == BK_DIVIDE) && !done;
  assign ram_we    = working && last_step;

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    issue      = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          pop        = 1'b1;
          state_next = BK_DIVIDE;
        end
      end
      BK_DIVIDE: begin
        if (done) begin
          state_next = BK_EMIT;
        end
      end
      BK_EMIT: begin
        issue = !rd_pending && (!out_valid || !out_stall);
        if (issue && (idx == '0)) begin
          state_next = BK_FINISH;
        end
      end
      BK_FINISH: begin
        state_next = BK_IDLE;
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      rd_pending <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (pop) begin
        cnt <= '0;
      end else if (ram_we) begin
        cnt <= cnt + CW'(1);
      end
      rd_pending <= issue;
      // a pending read always finds the output register free
      if (rd_pending) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      quo  <= QW'(q_mag);
      rem  <= '0;
      step <= '0;
      cur  <= q_ctrl;
    end else if (working) begin
      quo <= div_shift[QW-1:0];
      if (last_step) begin
        rem  <= '0;
        step <= '0;
      end else begin
        rem  <= r[RADIX_BITS-1:0];
        step <= step + SW'(1);
      end
    end
    if (done) begin
      idx <= AW'(cnt - CW'(1));
    end else if (issue) begin
      idx <= idx - AW'(1);
    end
    if (issue) begin
      last_pend <= (idx == '0);
    end
    if (rd_pending) begin
      char_code <= digit_char(ram_rdata, cur.upper);
      negative  <= cur.sign;
      last      <= last_pend;
    end
  end

  itra_ram #(
    .WIDTH (RADIX_BITS),
    .DEPTH (VALUE_WIDTH)
  ) u_digit_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt[AW-1:0]),
    .wdata (r[RADIX_BITS-1:0]),
    .raddr (idx),
    .rdata (ram_rdata)
  );

endmodule

[hw/rtl/integer_to_radix_ascii.sv]
// Top level of the integer to radix ASCII converter.
// Converts one VALUE_WIDTH-bit integer per input word into ASCII digits in radix 2..36
// (radix 0 or 1 means 10, above 36 means 36), most significant digit first, one output
// word per digit; a negative signed value is converted as its magnitude with the
// negative flag set on every digit, and zero gives a single '0'. A two-word queue sits
// between the input side and the converter, so up to two words are taken while a
// conversion runs. Each word is popped from the queue and divided down digit by digit (the
// remainder loop resolves eight quotient bits per cycle), then its digits are read from the
// digit store, whose read is registered, and are emitted as any output stall allows.
module integer_to_radix_ascii
  import itra_pkg::*;
  #(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
  )
  (
    input  logic                   clk,
    input  logic                   rst,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [FIELD_WIDTH-1:0] value_bits,
    input  logic                   is_signed,
    input  logic [RADIX_BITS-1:0]  radix,
    input  logic                   upper_case,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [CHAR_BITS-1:0]   char_code,
    output logic                   negative,
    output logic                   last
  );

  localparam int QDW = VALUE_WIDTH + $bits(conv_ctrl_t);

  logic                   push;
  logic                   pop;
  logic                   q_full;
  logic                   q_empty;
  logic [VALUE_WIDTH-1:0] f_mag;
  conv_ctrl_t             f_ctrl;
  logic [QDW-1:0]         q_data;
  logic [VALUE_WIDTH-1:0] q_mag;
  conv_ctrl_t             q_ctrl;

  assign q_mag  = q_data[QDW-1 -: VALUE_WIDTH];
  assign q_ctrl = q_data[$bits(conv_ctrl_t)-1:0];

  itra_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value_bits (value_bits),
    .is_signed  (is_signed),
    .radix      (radix),
    .upper_case (upper_case),
    .q_full     (q_full),
    .push       (push),
    .mag        (f_mag),
    .ctrl       (f_ctrl)
  );

  itra_queue #(
    .WIDTH (QDW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({f_mag, f_ctrl}),
    .pop       (pop),
    .pop_data  (q_data),
    .empty     (q_empty),
    .full      (q_full)
  );

  itra_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .pop       (pop),
    .q_mag     (q_mag),
    .q_ctrl    (q_ctrl),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .char_code (char_code),
    .negative  (negative),
    .last      (last)
  );

endmodule
